// File: rtl/cctsd_pkg.sv
package cctsd_pkg;

  // Filter start values and speed thresholds
  localparam logic [31:0] PRI_FILTER_START = 32'd1500;
  localparam logic [31:0] SEC_FILTER_START = 32'd833;
  localparam logic [15:0] LOW_RPM_LITE     = 16'd1400;

  // Tooth count before the first edge (no sync yet)
  localparam logic [6:0] TOOTH_NONE   = 7'd99;
  localparam logic [6:0] TEETH_FOUR   = 7'd8;
  localparam logic [6:0] TEETH_SIX    = 7'd12;

  // Degrees spanned by the last tooth gap
  localparam logic [7:0] ANGLE_ODD    = 8'd70;
  localparam logic [7:0] ANGLE_EVEN4  = 8'd110;
  localparam logic [7:0] ANGLE_EVEN6  = 8'd50;
  localparam logic [7:0] ANGLE_START  = 8'd180;

  localparam int unsigned REG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_SIX_CYLINDER    = 3'd0,
    REG_FILTER_LEVEL    = 3'd1,
    REG_CRANK_LOCK      = 3'd2,
    REG_STAGE_CYCLES    = 3'd3,
    REG_RESYNC_ENABLE   = 3'd4,
    REG_CRANK_RPM_LIMIT = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FILT_OFF        = 2'd0,
    FILT_LITE       = 2'd1,
    FILT_MEDIUM     = 2'd2,
    FILT_AGGRESSIVE = 2'd3
  } filt_level_e;

  typedef enum logic {
    EDGE_CRANK = 1'b0,
    EDGE_CAM   = 1'b1
  } edge_src_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] timestamp_us;
    logic        crank_level;
    logic        cam_level;
    logic [15:0] engine_rpm;
    logic        cranking;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  tooth_number;
    logic        synced;
    logic [7:0]  tooth_angle_deg;
    logic [3:0]  coil_end_mask;
    logic [7:0]  sync_loss_count;
    logic [31:0] tooth_gap_us;
  } out_item_t;

  // Gap times a small constant, shifted down, saturated to 32 bits
  function automatic logic [31:0] scale_sat(logic [31:0] gap, logic [3:0] mul,
                                            logic [2:0] sh);
    logic [35:0] prod;
    logic [35:0] shifted;
    prod    = {4'b0, gap} * {32'b0, mul};
    shifted = prod >> sh;
    return (|shifted[35:32]) ? 32'hFFFF_FFFF : shifted[31:0];
  endfunction

endpackage

// File: rtl/crank_cam_tooth_sync_decoder_core.sv
// Crank and cam tooth sync decoder.
// Input channel: in_valid_i / in_stall_o carry one edge item (source, timestamp,
// pin levels, speed, cranking flag). Output channel: out_valid_o / out_stall_i
// return exactly one result item per edge item, in order.
// An item is taken into an input register; from there the filter, tooth count,
// sync and window logic acts on it against the decoder state, updates that
// state and loads the result register, which drives out_valid_o, once that
// register is free. One item per cycle is sustained while the receiver does
// not stall, since the state update for one edge completes between the two
// registers.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; only then does in_stall_o rise.
// Reset clears both registers and returns the decoder to tooth 99 (no sync),
// filter windows to their start values and all registers of the APB port
// to their defaults. Registers sit at byte address 4*index; pready is always
// high and unknown addresses read zero and ignore writes.
module crank_cam_tooth_sync_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cctsd_pkg::in_item_t                 in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cctsd_pkg::out_item_t                out_item_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cctsd_pkg::REG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import cctsd_pkg::*;

  // Configuration registers
  logic        six_cyl_q;
  logic [1:0]  filt_level_q;
  logic        crank_lock_q;
  logic [7:0]  stage_cycles_q;
  logic        resync_q;
  logic [15:0] rpm_limit_q;

  // Pipeline registers
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t out_item_d;
  logic      advance;
  logic      step;

  // Decoder state
  logic [6:0]  tooth_q, tooth_d;
  logic [31:0] last_tooth_q, last_tooth_d;
  logic [31:0] crank_win_q, crank_win_d;
  logic [31:0] cam_win_q, cam_win_d;
  logic [31:0] last_cam_q, last_cam_d;
  logic [15:0] rev_q, rev_d;
  logic        sync_q, sync_d;
  logic        half_q, half_d;
  logic [7:0]  angle_q, angle_d;
  logic [7:0]  loss_q, loss_d;

  // Working signals
  logic [31:0] gap_crank, gap_cam, gap;
  logic [6:0]  teeth, tooth_inc;
  logic        odd;
  logic        lite;
  logic        acc;
  logic [3:0]  mask;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // APB register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      six_cyl_q      <= 1'b0;
      filt_level_q   <= FILT_LITE;
      crank_lock_q   <= 1'b0;
      stage_cycles_q <= 8'd0;
      resync_q       <= 1'b0;
      rpm_limit_q    <= 16'd400;
    end else if (wr_en) begin
      unique case (paddr[REG_ADDR_W-1:2])
        REG_SIX_CYLINDER:    six_cyl_q      <= pwdata[0];
        REG_FILTER_LEVEL:    filt_level_q   <= pwdata[1:0];
        REG_CRANK_LOCK:      crank_lock_q   <= pwdata[0];
        REG_STAGE_CYCLES:    stage_cycles_q <= pwdata[7:0];
        REG_RESYNC_ENABLE:   resync_q       <= pwdata[0];
        REG_CRANK_RPM_LIMIT: rpm_limit_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_ADDR_W-1:2])
      REG_SIX_CYLINDER:    prdata = {31'b0, six_cyl_q};
      REG_FILTER_LEVEL:    prdata = {30'b0, filt_level_q};
      REG_CRANK_LOCK:      prdata = {31'b0, crank_lock_q};
      REG_STAGE_CYCLES:    prdata = {24'b0, stage_cycles_q};
      REG_RESYNC_ENABLE:   prdata = {31'b0, resync_q};
      REG_CRANK_RPM_LIMIT: prdata = {16'b0, rpm_limit_q};
      default:             prdata = 32'b0;
    endcase
  end

  // Handshake: the result register frees when empty or taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign step       = in_valid_q && advance;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Edge processing against the decoder state
  assign gap_crank = in_item_q.timestamp_us - last_tooth_q;
  assign gap_cam   = in_item_q.timestamp_us - last_cam_q;
  assign teeth     = six_cyl_q ? TEETH_SIX : TEETH_FOUR;
  assign lite      = (filt_level_q == FILT_LITE) || (in_item_q.engine_rpm < LOW_RPM_LITE);

  always_comb begin
    tooth_d      = tooth_q;
    last_tooth_d = last_tooth_q;
    crank_win_d  = crank_win_q;
    cam_win_d    = cam_win_q;
    last_cam_d   = last_cam_q;
    rev_d        = rev_q;
    sync_d       = sync_q;
    half_d       = half_q;
    angle_d      = angle_q;
    loss_d       = loss_q;
    acc          = 1'b0;
    mask         = 4'b0;
    odd          = 1'b0;
    tooth_inc    = tooth_q + 7'd1;
    gap          = gap_cam;

    if (in_item_q.opcode == EDGE_CRANK) begin
      gap = gap_crank;
      if (gap_crank >= crank_win_q || rev_q == 16'd0) begin
        acc          = 1'b1;
        crank_win_d  = gap_crank >> 2;
        last_tooth_d = in_item_q.timestamp_us;
        // Wrap to tooth one after a full revolution of edges
        if (tooth_inc == 7'd1 || tooth_inc > teeth) begin
          tooth_inc = 7'd1;
          rev_d     = rev_q + 16'd1;
        end
        tooth_d = tooth_inc;
        odd     = tooth_inc[0] && (tooth_inc <= 7'd11);

        if (sync_q) begin
          // Wasted-spark coil ends while cranking
          if (in_item_q.cranking && crank_lock_q && rev_d >= {8'b0, stage_cycles_q}) begin
            if (!six_cyl_q) begin
              if (tooth_inc == 7'd1 || tooth_inc == 7'd5)      mask = 4'h5;
              else if (tooth_inc == 7'd3 || tooth_inc == 7'd7) mask = 4'hA;
            end else begin
              if (tooth_inc == 7'd1 || tooth_inc == 7'd7)       mask = 4'h1;
              else if (tooth_inc == 7'd3 || tooth_inc == 7'd9)  mask = 4'h2;
              else if (tooth_inc == 7'd5 || tooth_inc == 7'd11) mask = 4'h4;
            end
          end

          angle_d = odd ? ANGLE_ODD : (six_cyl_q ? ANGLE_EVEN6 : ANGLE_EVEN4);
          // Pick the next crank window from the gap and filter strength
          if (lite) begin
            if (odd)             crank_win_d = six_cyl_q ? (gap_crank >> 2) : gap_crank;
            else if (!six_cyl_q) crank_win_d = scale_sat(gap_crank, 4'd3, 3'd3);
            else                 crank_win_d = gap_crank >> 1;
          end else if (filt_level_q == FILT_MEDIUM) begin
            if (odd)             crank_win_d = six_cyl_q ? (gap_crank >> 1)
                                                         : scale_sat(gap_crank, 4'd5, 3'd2);
            else if (!six_cyl_q) crank_win_d = gap_crank >> 1;
            else                 crank_win_d = scale_sat(gap_crank, 4'd3, 3'd2);
          end else if (filt_level_q == FILT_AGGRESSIVE) begin
            if (odd)             crank_win_d = six_cyl_q ? (gap_crank >> 1)
                                                         : scale_sat(gap_crank, 4'd11, 3'd3);
            else if (!six_cyl_q) crank_win_d = scale_sat(gap_crank, 4'd9, 3'd5);
            else                 crank_win_d = gap_crank;
          end else begin
            crank_win_d = 32'd0;
          end
        end else begin
          // Hunt for a known tooth from the pin levels
          cam_win_d = 32'd0;
          if (in_item_q.crank_level) begin
            half_d = in_item_q.cam_level;
          end else if (half_q) begin
            if (!in_item_q.cam_level) begin
              if (!six_cyl_q) tooth_d = 7'd1;
            end else if (!six_cyl_q) begin
              tooth_d = 7'd5;
            end else begin
              tooth_d = 7'd2;
              sync_d  = 1'b1;
            end
          end
        end
      end
    end else begin
      if (gap_cam >= cam_win_q) begin
        acc        = 1'b1;
        last_cam_d = in_item_q.timestamp_us;
        cam_win_d  = gap_cam >> 1;
        if (!sync_q) begin
          crank_win_d = PRI_FILTER_START;
          cam_win_d   = gap_cam >> 2;
          if (in_item_q.crank_level) begin
            if (six_cyl_q ? (tooth_q == 7'd7) : (tooth_q == 7'd8)) sync_d = 1'b1;
          end else if (!six_cyl_q && tooth_q == 7'd5) begin
            sync_d = 1'b1;
          end
        end
        // Drop four cylinder sync on a cam edge with crank high away from tooth eight, when slow or with resync on
        if (in_item_q.engine_rpm < rpm_limit_q || resync_q) begin
          if (sync_d && !six_cyl_q && in_item_q.crank_level && tooth_q != 7'd8) begin
            sync_d = 1'b0;
            loss_d = loss_q + 8'd1;
          end
        end
      end
    end

    out_item_d.accepted        = acc;
    out_item_d.tooth_number    = tooth_d;
    out_item_d.synced          = sync_d;
    out_item_d.tooth_angle_deg = angle_d;
    out_item_d.coil_end_mask   = mask;
    out_item_d.sync_loss_count = loss_d;
    out_item_d.tooth_gap_us    = gap;
  end

  // Pipeline control and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      tooth_q      <= TOOTH_NONE;
      last_tooth_q <= 32'd0;
      crank_win_q  <= PRI_FILTER_START;
      cam_win_q    <= SEC_FILTER_START;
      last_cam_q   <= 32'd0;
      rev_q        <= 16'd0;
      sync_q       <= 1'b0;
      half_q       <= 1'b0;
      angle_q      <= ANGLE_START;
      loss_q       <= 8'd0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        tooth_q      <= tooth_d;
        last_tooth_q <= last_tooth_d;
        crank_win_q  <= crank_win_d;
        cam_win_q    <= cam_win_d;
        last_cam_q   <= last_cam_d;
        rev_q        <= rev_d;
        sync_q       <= sync_d;
        half_q       <= half_d;
        angle_q      <= angle_d;
        loss_q       <= loss_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= out_item_d;
    end
  end

  // The loss counter moves only when sync is dropped
  a_loss_on_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (loss_q != $past(loss_q)) |-> ($past(sync_q) && !sync_q))
    else $error("sync loss counted without a sync drop");

  // Tooth count is either the no-sync marker or a real tooth
  a_tooth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tooth_q == TOOTH_NONE) || (tooth_q >= 7'd1 && tooth_q <= TEETH_SIX))
    else $error("tooth count out of range");

  // A result appears only for an item held in the input register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without an input item");

  // Coil ends come only from accepted edges with sync held
  a_mask_synced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.coil_end_mask != 4'b0) |->
      (out_item_q.accepted && out_item_q.synced))
    else $error("coil end without sync");

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cctsd_pkg::*;

  // Cycles with no item moving on either channel before the run is declared hung
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned EDGES_PER_PHASE = 194;
  // Pipeline depth plus margin, used before register writes and at the end
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned SHOWN_ERRORS    = 10;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [REG_ADDR_W-1:0] paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;

  crank_cam_tooth_sync_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // Decoder shadow: settings and engine-position state, mirrored in the bench
  // ---------------------------------------------------------------------------
  logic        cfg_six;
  filt_level_e cfg_filt;
  logic        cfg_lock;
  logic [7:0]  cfg_stage;
  logic        cfg_resync;
  logic [15:0] cfg_rpm_lim;

  logic [6:0]  tooth_cnt;
  logic [31:0] last_crank_ts;
  logic [31:0] crank_win;
  logic [31:0] cam_win;
  logic [31:0] last_cam_ts;
  logic [15:0] rev_cnt;
  logic        sync_q;
  logic        half_q;
  logic [7:0]  angle_q;
  logic [7:0]  loss_q;

  in_item_t  pending_edges[$];
  out_item_t predicted_results[$];

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned mismatches   = 0;
  int unsigned edges_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned rejected     = 0;
  int unsigned synced_seen  = 0;
  int unsigned coil_marks   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned phases_run   = 0;

  // Synthetic engine used to shape well-formed wheel sequences
  logic [31:0] crank_clock;
  int unsigned wheel_pos;
  int unsigned us_per_deg;
  logic [15:0] seg_rpm;
  logic        seg_cranking;

  function automatic void reset_shadow();
    cfg_six       = 1'b0;
    cfg_filt      = FILT_LITE;
    cfg_lock      = 1'b0;
    cfg_stage     = 8'd0;
    cfg_resync    = 1'b0;
    cfg_rpm_lim   = 16'd400;
    tooth_cnt     = TOOTH_NONE;
    last_crank_ts = '0;
    crank_win     = PRI_FILTER_START;
    cam_win       = SEC_FILTER_START;
    last_cam_ts   = '0;
    rev_cnt       = '0;
    sync_q        = 1'b0;
    half_q        = 1'b0;
    angle_q       = ANGLE_START;
    loss_q        = '0;
  endfunction

  // Gap multiple at full precision, saturated to 32 bits
  function automatic logic [31:0] gap_mult(logic [31:0] gap, int unsigned mul,
                                           int unsigned sh);
    logic [63:0] wide;
    wide = (64'(gap) * 64'(mul)) >> sh;
    return (wide[63:32] != '0) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  // Advance the shadow by one edge item and return the result it should give
  function automatic out_item_t decode_edge(in_item_t it);
    out_item_t   r;
    logic [31:0] gap;
    logic [6:0]  teeth;
    logic        odd;
    r = '0;
    if (it.opcode == EDGE_CRANK) begin
      gap = it.timestamp_us - last_crank_ts;
      r.tooth_gap_us = gap;
      if (gap >= crank_win || rev_cnt == '0) begin
        r.accepted    = 1'b1;
        crank_win     = gap >> 2;
        last_crank_ts = it.timestamp_us;
        tooth_cnt     = tooth_cnt + 7'd1;
        teeth         = cfg_six ? TEETH_SIX : TEETH_FOUR;
        if (tooth_cnt == 7'd1 || tooth_cnt > teeth) begin
          tooth_cnt = 7'd1;
          rev_cnt   = rev_cnt + 16'd1;
        end
        if (sync_q) begin
          if (it.cranking && cfg_lock && rev_cnt >= {8'd0, cfg_stage}) begin
            if (!cfg_six) begin
              if (tooth_cnt == 7'd1 || tooth_cnt == 7'd5)      r.coil_end_mask = 4'b0101;
              else if (tooth_cnt == 7'd3 || tooth_cnt == 7'd7) r.coil_end_mask = 4'b1010;
            end else begin
              if (tooth_cnt == 7'd1 || tooth_cnt == 7'd7)       r.coil_end_mask = 4'b0001;
              else if (tooth_cnt == 7'd3 || tooth_cnt == 7'd9)  r.coil_end_mask = 4'b0010;
              else if (tooth_cnt == 7'd5 || tooth_cnt == 7'd11) r.coil_end_mask = 4'b0100;
            end
          end
          odd = tooth_cnt[0] && tooth_cnt <= 7'd11;
          if (cfg_filt == FILT_LITE || it.engine_rpm < LOW_RPM_LITE) begin
            if (odd) begin
              angle_q   = ANGLE_ODD;
              crank_win = cfg_six ? (gap >> 2) : gap;
            end else if (!cfg_six) begin
              angle_q   = ANGLE_EVEN4;
              crank_win = gap_mult(gap, 3, 3);
            end else begin
              angle_q   = ANGLE_EVEN6;
              crank_win = gap >> 1;
            end
          end else if (cfg_filt == FILT_MEDIUM) begin
            if (odd) begin
              angle_q   = ANGLE_ODD;
              crank_win = cfg_six ? (gap >> 1) : gap_mult(gap, 5, 2);
            end else if (!cfg_six) begin
              angle_q   = ANGLE_EVEN4;
              crank_win = gap >> 1;
            end else begin
              angle_q   = ANGLE_EVEN6;
              crank_win = gap_mult(gap, 3, 2);
            end
          end else if (cfg_filt == FILT_AGGRESSIVE) begin
            if (odd) begin
              angle_q   = ANGLE_ODD;
              crank_win = cfg_six ? (gap >> 1) : gap_mult(gap, 11, 3);
            end else if (!cfg_six) begin
              angle_q   = ANGLE_EVEN4;
              crank_win = gap_mult(gap, 9, 5);
            end else begin
              angle_q   = ANGLE_EVEN6;
              crank_win = gap;
            end
          end else begin
            crank_win = '0;
            angle_q   = odd ? ANGLE_ODD : (cfg_six ? ANGLE_EVEN6 : ANGLE_EVEN4);
          end
        end else begin
          // Hunt for a known tooth from the pin levels
          cam_win = '0;
          if (it.crank_level) begin
            half_q = it.cam_level;
          end else if (half_q) begin
            if (!it.cam_level) begin
              if (!cfg_six) tooth_cnt = 7'd1;
            end else if (!cfg_six) begin
              tooth_cnt = 7'd5;
            end else begin
              tooth_cnt = 7'd2;
              sync_q    = 1'b1;
            end
          end
        end
      end
    end else begin
      gap = it.timestamp_us - last_cam_ts;
      r.tooth_gap_us = gap;
      if (gap >= cam_win) begin
        r.accepted  = 1'b1;
        last_cam_ts = it.timestamp_us;
        cam_win     = gap >> 1;
        if (!sync_q) begin
          crank_win = PRI_FILTER_START;
          cam_win   = cam_win >> 1;
          if (it.crank_level) begin
            if (cfg_six ? (tooth_cnt == 7'd7) : (tooth_cnt == TEETH_FOUR)) sync_q = 1'b1;
          end else if (!cfg_six && tooth_cnt == 7'd5) begin
            sync_q = 1'b1;
          end
        end
        if (it.engine_rpm < cfg_rpm_lim || cfg_resync) begin
          if (sync_q && !cfg_six && it.crank_level && tooth_cnt != TEETH_FOUR) begin
            sync_q = 1'b0;
            loss_q = loss_q + 8'd1;
          end
        end
      end
    end
    r.tooth_number    = tooth_cnt;
    r.synced          = sync_q;
    r.tooth_angle_deg = angle_q;
    r.sync_loss_count = loss_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued edge items; hold an item steady while it is stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        // Predict at the moment of acceptance so the shadow follows DUT order
        predicted_results.push_back(decode_edge(in_item_i));
        edges_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_edges.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_edges.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results, compare each field against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      if (mismatches < SHOWN_ERRORS)
        $display("[%0t] result %0d field %s: expected 0x%0h, got 0x%0h",
                 $realtime, results_seen, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (predicted_results.size() == 0) begin
      if (mismatches < SHOWN_ERRORS)
        $display("[%0t] result with nothing predicted: 0x%0h", $realtime, got);
      mismatches++;
    end else begin
      want = predicted_results.pop_front();
      check_field("accepted",        32'(got.accepted),        32'(want.accepted));
      check_field("tooth_number",    32'(got.tooth_number),    32'(want.tooth_number));
      check_field("synced",          32'(got.synced),          32'(want.synced));
      check_field("tooth_angle_deg", 32'(got.tooth_angle_deg), 32'(want.tooth_angle_deg));
      check_field("coil_end_mask",   32'(got.coil_end_mask),   32'(want.coil_end_mask));
      check_field("sync_loss_count", 32'(got.sync_loss_count), 32'(want.sync_loss_count));
      check_field("tooth_gap_us",    got.tooth_gap_us,         want.tooth_gap_us);
      if (!want.accepted) rejected++;
      if (want.synced) synced_seen++;
      if (want.coil_end_mask != '0) coil_marks++;
    end
    results_seen++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_item_o);
      out_stall_i <= ($urandom_range(0, 99) < recv_gap_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("crank_cam_tooth_sync_decoder_core regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register port: setup cycle, then access cycle; mirror the write
  // ---------------------------------------------------------------------------
  task automatic apb_write(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SIX_CYLINDER:    cfg_six     = val[0];
      REG_FILTER_LEVEL:    cfg_filt    = filt_level_e'(val[1:0]);
      REG_CRANK_LOCK:      cfg_lock    = val[0];
      REG_STAGE_CYCLES:    cfg_stage   = val[7:0];
      REG_RESYNC_ENABLE:   cfg_resync  = val[0];
      REG_CRANK_RPM_LIMIT: cfg_rpm_lim = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_decoder(logic six, filt_level_e filt, logic lock,
                                 logic [7:0] stage, logic resync, logic [15:0] lim);
    apb_write(REG_SIX_CYLINDER,    32'(six));
    apb_write(REG_FILTER_LEVEL,    32'(filt));
    apb_write(REG_CRANK_LOCK,      32'(lock));
    apb_write(REG_STAGE_CYCLES,    32'(stage));
    apb_write(REG_RESYNC_ENABLE,   32'(resync));
    apb_write(REG_CRANK_RPM_LIMIT, 32'(lim));
  endtask

  // Hold the sender until every predicted result has come back, then let
  // the pipeline settle
  task automatic wait_drained();
    while (pending_edges.size() != 0 || in_valid_i || predicted_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_edge(edge_src_e src, logic [31:0] ts, logic crank, logic cam,
                           logic [15:0] rpm, logic crk);
    in_item_t it;
    it.opcode       = src;
    it.timestamp_us = ts;
    it.crank_level  = crank;
    it.cam_level    = cam;
    it.engine_rpm   = rpm;
    it.cranking     = crk;
    pending_edges.push_back(it);
  endtask

  function automatic logic [15:0] pick_rpm();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 1399));
      1:       return 16'($urandom_range(1400, 8000));
      2:       return 16'($urandom_range(0, 65535));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  // Queue a run of wheel edges: mostly a plausible trigger pattern with cam
  // edges in sync-relevant places, salted with flipped levels, noise edges,
  // huge gaps and fully random items
  task automatic queue_engine_run(int unsigned count);
    int unsigned teeth;
    int unsigned deg;
    int unsigned span;
    int unsigned roll;
    int unsigned start;
    logic        crank;
    logic        cam;
    start = pending_edges.size();
    while (pending_edges.size() < start + count) begin
      teeth = cfg_six ? 12 : 8;
      if (wheel_pos >= teeth) begin
        // New revolution: drift the operating point now and then
        wheel_pos = 0;
        if ($urandom_range(0, 4) == 0)
          us_per_deg = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 4000)
                                                   : $urandom_range(2, 200);
        if ($urandom_range(0, 2) == 0) seg_rpm = pick_rpm();
        if ($urandom_range(0, 3) == 0) seg_cranking = 1'($urandom_range(0, 1));
      end
      wheel_pos++;
      deg  = wheel_pos[0] ? 70 : (cfg_six ? 50 : 110);
      span = deg * us_per_deg;
      crank_clock += span + $urandom_range(0, span / 8);
      crank = !wheel_pos[0];
      cam   = (wheel_pos >= teeth / 2);
      roll  = $urandom_range(0, 99);
      if (roll < 4) begin
        crank = !crank;
      end else if (roll < 8) begin
        cam = !cam;
      end else if (roll < 12) begin
        push_edge(EDGE_CRANK, crank_clock - $urandom_range(1, span / 2),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), seg_rpm, seg_cranking);
      end else if (roll < 14) begin
        crank_clock += $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
      end else if (roll < 17) begin
        push_edge(edge_src_e'($urandom_range(0, 1)), $urandom(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      push_edge(EDGE_CRANK, crank_clock, crank, cam, seg_rpm, seg_cranking);
      // Cam edges where they gain sync, confirm it, or (rarely) break it
      if (wheel_pos == teeth / 2 + 1 || wheel_pos == teeth ||
          (wheel_pos == teeth / 2 && roll >= 90))
        push_edge(EDGE_CAM, crank_clock + span / 4, crank, 1'($urandom_range(0, 1)),
                  seg_rpm, seg_cranking);
    end
  endtask

  // Short directed opening at reset settings
  task automatic queue_directed();
    // first edge after reset: tooth 99 rolls over, first-revolution bypass
    push_edge(EDGE_CRANK, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0);
    // two cam edges, both taken since the crank edge cleared the cam window
    push_edge(EDGE_CAM,   32'd100,       1'b0, 1'b0, 16'hFFFF, 1'b1);
    push_edge(EDGE_CAM,   32'd833,       1'b0, 1'b0, 16'h0000, 1'b0);
    // crank inside the restored start window
    push_edge(EDGE_CRANK, 32'd1000,      1'b1, 1'b1, 16'd1399, 1'b1);
    push_edge(EDGE_CRANK, 32'd2600,      1'b1, 1'b1, 16'd1399, 1'b1);
    // crank low with first half set and cam high: jump to tooth five
    push_edge(EDGE_CRANK, 32'd5000,      1'b0, 1'b1, 16'd1400, 1'b0);
    // cam with crank low at tooth five gains sync
    push_edge(EDGE_CAM,   32'hFFFF_FFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0);
    push_edge(EDGE_CRANK, 32'd8000,      1'b1, 1'b1, 16'h0000, 1'b1);
    push_edge(EDGE_CRANK, 32'd10000,     1'b0, 1'b1, 16'hFFFF, 1'b1);
    // noise edge inside the window
    push_edge(EDGE_CRANK, 32'd11000,     1'b1, 1'b1, 16'hFFFF, 1'b1);
    push_edge(EDGE_CRANK, 32'd13000,     1'b1, 1'b1, 16'h0000, 1'b1);
    // cam at tooth eight with crank high; gap wraps past zero; the wide cam window rejects it
    push_edge(EDGE_CAM,   32'd13100,     1'b1, 1'b1, 16'h0000, 1'b1);
    push_edge(EDGE_CRANK, 32'd16000,     1'b0, 1'b0, 16'h0000, 1'b1);
    // cam with crank high away from tooth eight while slow: rejected by the cam window, sync kept
    push_edge(EDGE_CAM,   32'd40000,     1'b1, 1'b0, 16'h0000, 1'b1);
    push_edge(EDGE_CRANK, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, 1'b0);
    // crank gap wrapping through zero
    push_edge(EDGE_CRANK, 32'h0000_0010, 1'b0, 1'b1, 16'hFFFF, 1'b0);
  endtask

  task automatic apply_phase_settings(int unsigned phase);
    logic [15:0] lim;
    case (phase)
      1: program_decoder(1'b1, FILT_AGGRESSIVE, 1'b1, 8'd0, 1'b0, 16'hFFFF);
      2: program_decoder(1'b0, FILT_OFF, 1'b1, 8'd255, 1'b1, 16'h0000);
      3: program_decoder(1'b0, FILT_MEDIUM, 1'b1, 8'd2, 1'b0, 16'd1400);
      default: begin
        lim = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 3000));
        program_decoder(1'($urandom_range(0, 1)), filt_level_e'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)), 8'($urandom_range(0, 30)),
                        1'($urandom_range(0, 1)), lim);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed opening, then phases of settings and idling
  // ---------------------------------------------------------------------------
  initial begin
    reset_shadow();
    crank_clock  = $urandom();
    wheel_pos    = 99;
    us_per_deg   = 20;
    seg_rpm      = 16'd300;
    seg_cranking = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      // Registers change only with the decoder empty
      if (phase != 0) apply_phase_settings(phase);
      // Idling: sender-light first, then receiver-light, then none at all
      if (phase < 3) begin
        send_gap_pct = 13;
        recv_gap_pct = 56;
      end else if (phase < 6) begin
        send_gap_pct = 56;
        recv_gap_pct = 13;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      queue_engine_run(EDGES_PER_PHASE / 2);
      // Pause the sender mid-phase until every result is back
      wait_drained();
      queue_engine_run(EDGES_PER_PHASE - EDGES_PER_PHASE / 2);
      wait_drained();
      phases_run++;
    end
    mismatches += predicted_results.size();
    $display("ran %0d edge items over %0d register settings, %0d results checked",
             edges_taken, phases_run, results_seen);
    $display("%0d edges filtered out, %0d results in sync, %0d coil end marks, %0d sync losses",
             rejected, synced_seen, coil_marks, loss_q);
    if (mismatches == 0) begin
      $display("crank_cam_tooth_sync_decoder_core regression: pass");
    end else begin
      $display("crank_cam_tooth_sync_decoder_core regression: fail");
    end
    $finish;
  end

endmodule

// File: crank_cam_tooth_sync_decoder_core.f
rtl/cctsd_pkg.sv
rtl/crank_cam_tooth_sync_decoder_core.sv
bench/tb.sv
